[rtl/core/bcrw_pkg.sv]
// Shared types, constants and corner logic for the corner rounding window.
`default_nettype none

package bcrw_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int COL_W       = 7;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CFG_W       = 8;

    localparam logic REG_ROW_WIDTH = 1'b0;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             centre;
        logic             upper_left;
        logic             upper_right;
        logic             lower_left;
        logic             lower_right;
        logic             row_end;
    } res_t;

    typedef struct packed {
        logic             acc;
        logic             clear;
        logic [COL_W-1:0] wr_addr;
        logic [1:0]       wr_data;
        logic [COL_W-1:0] rd_addr;
    } rb_ctrl_t;

    // window bit k*3+y: k is column (left, centre, right), y is row (top, mid, bottom)
    function automatic res_t make_res(input logic [8:0] win, input logic [COL_W-1:0] col,
                                      input logic last);
        res_t r;
        logic c, up, dn, lf, rt;
        c  = win[4];
        up = win[3];
        dn = win[5];
        lf = win[1];
        rt = win[7];
        r.column = col;
        r.centre = c;
        if (c)
        begin
            r.upper_left  = lf | up | win[0];
            r.upper_right = up | rt | win[6];
            r.lower_left  = lf | dn | win[2];
            r.lower_right = rt | dn | win[8];
        end
        else
        begin
            r.upper_left  = lf & up;
            r.upper_right = up & rt;
            r.lower_left  = lf & dn;
            r.lower_right = rt & dn;
        end
        r.row_end = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bcrw_row_buf.sv]
// Two-row history memory with prefetched read, write bypass and per-column valid bits.
`default_nettype none

module bcrw_row_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcrw_pkg::rb_ctrl_t ctrl,
    output logic [1:0]             rd_bits
);

    logic [1:0] mem [bcrw_pkg::MAX_WIDTH];
    logic [bcrw_pkg::MAX_WIDTH-1:0] valid_reg, valid_next;
    logic [1:0] rd_data_reg;
    logic       rd_valid_reg;

    always_comb
    begin
        valid_next = ctrl.clear ? '0 : valid_reg;
        valid_next[ctrl.wr_addr] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
            if (ctrl.rd_addr == ctrl.wr_addr)
            begin
                rd_data_reg <= ctrl.wr_data;
            end
            else
            begin
                rd_data_reg <= mem[ctrl.rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (ctrl.acc)
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_addr == ctrl.wr_addr)
            begin
                rd_valid_reg <= 1'b1;
            end
            else
            begin
                rd_valid_reg <= !ctrl.clear && valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_bits = rd_valid_reg ? rd_data_reg : 2'b00;

endmodule

`default_nettype wire

[rtl/core/bcrw_res_fifo.sv]
// Small result queue taking up to two results per cycle and giving one while rsp_stall is low.
`default_nettype none

module bcrw_res_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [1:0]     push_n,
    input  wire bcrw_pkg::res_t push_a,
    input  wire bcrw_pkg::res_t push_b,
    output logic                full2,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bcrw_pkg::res_t      rsp_data
);

    bcrw_pkg::res_t q [bcrw_pkg::FIFO_DEPTH];
    logic [bcrw_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bcrw_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bcrw_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bcrw_pkg::PTR_W-1:0] wr_ptr_b;
    logic                       pop;

    assign pop       = rsp_valid && !rsp_stall;
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;
    assign rsp_valid = count_reg != '0;
    assign rsp_data  = q[rd_ptr_reg];
    assign full2     = count_reg > bcrw_pkg::CNT_W'(bcrw_pkg::FIFO_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + bcrw_pkg::PTR_W'(pop);
        count_next  = count_reg + bcrw_pkg::CNT_W'(push_n) - bcrw_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            q[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_corner_rounding_window.sv]
// Top level of the corner rounding window: counters, window, config port and checks.
`default_nettype none

// Streams a one-bit raster in row order, one pixel per clock, and for each cell of the
// previous row gives its centre bit and four rounded-corner bits. A new pixel is taken every
// cycle while fewer than three results wait; a row of row_width pixels yields row_width
// results, the last column giving two results in one cycle when the row is wider than one,
// absorbed by a four-entry result queue that drains one per cycle while rsp_stall is low.
// Row history lives in a 128x2 memory read one column ahead, so a pixel's results are
// queued at the edge that takes it and show at the output once earlier results have gone.
// Output starts with the second row; end each image with a blank row. frame_start clears
// all history at once. row_width 0 acts as 1 and values above 128 act as 128.
module bitmap_corner_rounding_window (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            pixel,
    input  wire logic                            frame_start,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic [bcrw_pkg::COL_W-1:0]           column,
    output logic                                 centre,
    output logic                                 upper_left,
    output logic                                 upper_right,
    output logic                                 lower_left,
    output logic                                 lower_right,
    output logic                                 row_end,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcrw_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bcrw_pkg::PDATA_W-1:0]    pwdata,
    output logic [bcrw_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [bcrw_pkg::CFG_W-1:0] row_width_reg;
    logic [bcrw_pkg::COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]                 rows_seen_reg, rows_seen_next;
    logic [8:0]                 win_reg, win_next;

    logic                       req_acc;
    logic                       full2;
    logic [bcrw_pkg::COL_W-1:0] c_cur, wm1;
    logic                       last, active;
    logic [1:0]                 rd_bits;
    logic                       top, mid;
    logic [2:0]                 colv;
    logic [8:0]                 win2;
    logic                       first_en, second_en;
    logic [1:0]                 push_n;
    bcrw_pkg::res_t             res_first, res_second, push_a, push_b, rsp_data;
    bcrw_pkg::rb_ctrl_t         rb_ctrl;
    logic [1:0]                 base_rows;

    assign pready    = 1'b1;
    assign req_stall = full2;
    assign req_acc   = req_valid && !req_stall;

    always_comb
    begin
        if (paddr[2] == bcrw_pkg::REG_ROW_WIDTH)
        begin
            prdata = bcrw_pkg::PDATA_W'(row_width_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= bcrw_pkg::CFG_W'(bcrw_pkg::MAX_WIDTH);
        end
        else if (psel && penable && pwrite && pready && paddr[2] == bcrw_pkg::REG_ROW_WIDTH)
        begin
            row_width_reg <= pwdata[bcrw_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (row_width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (row_width_reg > bcrw_pkg::CFG_W'(bcrw_pkg::MAX_WIDTH))
        begin
            wm1 = bcrw_pkg::COL_W'(bcrw_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = bcrw_pkg::COL_W'(row_width_reg - 1'b1);
        end
    end

    always_comb
    begin
        c_cur     = frame_start ? '0 : col_cnt_reg;
        last      = c_cur >= wm1;
        active    = !frame_start && rows_seen_reg != 2'd0;
        top       = !frame_start && rd_bits[1];
        mid       = !frame_start && rd_bits[0];
        colv      = {pixel, mid, top};
        if (c_cur == '0)
        begin
            win_next = {colv, 6'b0};
        end
        else
        begin
            win_next = {colv, win_reg[8:3]};
        end
        win2      = {3'b000, win_next[8:3]};
        first_en  = active && c_cur != '0;
        second_en = active && last;
        res_first  = bcrw_pkg::make_res(win_next, c_cur - 1'b1, 1'b0);
        res_second = bcrw_pkg::make_res(win2, c_cur, 1'b1);
        push_a     = first_en ? res_first : res_second;
        push_b     = res_second;
        if (!req_acc)
        begin
            push_n = 2'd0;
        end
        else
        begin
            push_n = {1'b0, first_en} + {1'b0, second_en};
        end
        col_cnt_next = last ? '0 : c_cur + 1'b1;
        base_rows    = frame_start ? 2'd0 : rows_seen_reg;
        if (last && base_rows != 2'd3)
        begin
            rows_seen_next = base_rows + 1'b1;
        end
        else
        begin
            rows_seen_next = base_rows;
        end
        rb_ctrl.acc     = req_acc;
        rb_ctrl.clear   = frame_start;
        rb_ctrl.wr_addr = c_cur;
        rb_ctrl.wr_data = {mid, pixel};
        rb_ctrl.rd_addr = col_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            rows_seen_reg <= '0;
            win_reg       <= '0;
        end
        else if (req_acc)
        begin
            col_cnt_reg   <= col_cnt_next;
            rows_seen_reg <= rows_seen_next;
            win_reg       <= win_next;
        end
    end

    bcrw_row_buf u_row_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rb_ctrl),
        .rd_bits (rd_bits)
    );

    bcrw_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .full2     (full2),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    assign column      = rsp_data.column;
    assign centre      = rsp_data.centre;
    assign upper_left  = rsp_data.upper_left;
    assign upper_right = rsp_data.upper_right;
    assign lower_left  = rsp_data.lower_left;
    assign lower_right = rsp_data.lower_right;
    assign row_end     = rsp_data.row_end;

`ifndef SYNTH
    a_no_result_in_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (rows_seen_reg != 2'd0 && !frame_start))
        else $error("result produced before second row");

    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && last) |=> (col_cnt_reg == '0))
        else $error("column counter did not wrap");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && frame_start && wm1 != '0) |=> (col_cnt_reg == 7'd1 && rows_seen_reg == 2'd0))
        else $error("frame start did not restart the row");
`endif

endmodule

`default_nettype wire
